// ===== design/lcdseq_pkg.sv =====
package lcdseq_pkg;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_WRITE = 2'd2,
		OP_BLINK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_ENABLE_PULSE_US   = 3'd0,
		CFG_POWER_ON_DELAY_MS = 3'd1,
		CFG_SETTLE_DELAY_MS   = 3'd2,
		CFG_CLEAR_DELAY_MS    = 3'd3,
		CFG_PANEL_COLUMNS     = 3'd4
	} cfg_index_t;

	localparam logic [7:0] CMD_FUNCTION_SET  = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
	localparam logic [7:0] CMD_CLEAR         = 8'h01;
	localparam logic [7:0] CURSOR_BLINK_BITS = 8'h03;
	localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;
	localparam logic [6:0] ROW1_BASE         = 7'h40;

	localparam logic [2:0] FUNCTION_SET_REPEATS = 3'd3;
	localparam logic [2:0] INIT_TRANSFERS       = 3'd5;
	localparam logic [2:0] WRITE_TRANSFERS      = 3'd2;
	localparam logic [2:0] SINGLE_TRANSFER      = 3'd1;
	localparam logic [2:0] NO_TRANSFER          = 3'd0;

	typedef struct packed {
		logic [7:0] power_on_delay_ms;
		logic [7:0] settle_delay_ms;
		logic [7:0] clear_delay_ms;
		logic [5:0] panel_columns;
	} cfg_t;

	// One decoded request as it waits for its transfers to go out.
	typedef struct packed {
		op_t        op;
		logic [2:0] count;
		logic [7:0] cmd_byte;
		logic [7:0] char_byte;
	} desc_t;

endpackage

// ===== design/lcdseq_cfg.sv =====
module lcdseq_cfg
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg     = cfg_q;

	// The enable strobe length is taken for the bus driver and has no effect on
	// any transfer this block produces, so a write to it is accepted and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on_delay_ms <= 8'd50;
			cfg_q.settle_delay_ms   <= 8'd5;
			cfg_q.clear_delay_ms    <= 8'd2;
			cfg_q.panel_columns     <= 6'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POWER_ON_DELAY_MS: cfg_q.power_on_delay_ms <= cfg_data;
				CFG_SETTLE_DELAY_MS:   cfg_q.settle_delay_ms   <= cfg_data;
				CFG_CLEAR_DELAY_MS:    cfg_q.clear_delay_ms    <= cfg_data;
				CFG_PANEL_COLUMNS:     cfg_q.panel_columns     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/lcdseq_decode.sv =====
module lcdseq_decode
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic       row,
	input  logic [5:0] column,
	input  logic [7:0] character,
	input  logic       string_last,
	input  logic       blink_on,
	input  logic       release_s1,
	output logic       valid_s1,
	output desc_t      desc_s1
);

	logic       string_row_q;
	logic [6:0] next_column_q;
	logic       inside_string_q;

	logic       accept;
	logic       cur_row;
	logic [6:0] cur_col;
	logic       fits;
	logic [6:0] addr;
	op_t        op;
	desc_t      desc;

	assign op       = op_t'(operation);
	assign in_stall = valid_s1 && !release_s1;
	assign accept   = in_valid && !in_stall;

	// The first character of a string takes its place from the request; the
	// rest continue at the running column.
	assign cur_row = inside_string_q ? string_row_q : row;
	assign cur_col = inside_string_q ? next_column_q : {1'b0, column};
	assign fits    = cur_col < {1'b0, cfg.panel_columns};
	assign addr    = (cur_row ? ROW1_BASE : 7'd0) + cur_col;

	always_comb begin
		desc.op        = op;
		desc.count     = NO_TRANSFER;
		desc.cmd_byte  = CMD_CLEAR;
		desc.char_byte = character;
		case (op)
			OP_INIT: begin
				desc.count = INIT_TRANSFERS;
			end
			OP_CLEAR: begin
				desc.count = SINGLE_TRANSFER;
			end
			OP_WRITE: begin
				desc.count    = fits ? WRITE_TRANSFERS : NO_TRANSFER;
				desc.cmd_byte = CMD_SET_DDRAM | {1'b0, addr};
			end
			OP_BLINK: begin
				desc.count    = SINGLE_TRANSFER;
				desc.cmd_byte = CMD_DISPLAY_ON | (blink_on ? CURSOR_BLINK_BITS : 8'd0);
			end
			default: begin
				desc.count = NO_TRANSFER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_row_q    <= 1'b0;
			next_column_q   <= 7'd0;
			inside_string_q <= 1'b0;
			valid_s1        <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (op == OP_WRITE) begin
				string_row_q    <= cur_row;
				next_column_q   <= fits ? cur_col + 7'd1 : cur_col;
				inside_string_q <= !string_last;
			end else begin
				inside_string_q <= 1'b0;
			end
		end else if (release_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

endmodule

// ===== design/lcdseq_emit.sv =====
module lcdseq_emit
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       valid_s1,
	input  desc_t      desc_s1,
	output logic       release_s1,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reg_select,
	output logic [7:0] bus_byte,
	output logic [7:0] pause_before_ms,
	output logic [7:0] pause_after_ms,
	output logic       is_last
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       reg_select_q;
	logic [7:0] bus_byte_q;
	logic [7:0] pause_before_q;
	logic [7:0] pause_after_q;
	logic       is_last_q;

	logic       advance;
	logic       emitting;
	logic       final_xfer;
	logic       nx_rs;
	logic [7:0] nx_byte;
	logic [7:0] nx_before;
	logic [7:0] nx_after;

	assign advance    = !out_valid_q || !out_stall;
	assign emitting   = valid_s1 && (desc_s1.count != NO_TRANSFER) && advance;
	assign final_xfer = idx_q == (desc_s1.count - 3'd1);
	// A dropped character has nothing to send and frees the stage at once.
	assign release_s1 = valid_s1 && ((desc_s1.count == NO_TRANSFER) || (advance && final_xfer));

	always_comb begin
		nx_rs     = 1'b0;
		nx_byte   = desc_s1.cmd_byte;
		nx_before = 8'd0;
		nx_after  = 8'd0;
		case (desc_s1.op)
			OP_INIT: begin
				if (idx_q < FUNCTION_SET_REPEATS) begin
					nx_byte   = CMD_FUNCTION_SET;
					nx_before = (idx_q == 3'd0) ? cfg.power_on_delay_ms : 8'd0;
					nx_after  = cfg.settle_delay_ms;
				end else if (idx_q == FUNCTION_SET_REPEATS) begin
					nx_byte  = CMD_DISPLAY_ON;
					nx_after = cfg.settle_delay_ms;
				end else begin
					nx_byte  = CMD_CLEAR;
					nx_after = cfg.clear_delay_ms;
				end
			end
			OP_CLEAR: begin
				nx_byte  = CMD_CLEAR;
				nx_after = cfg.clear_delay_ms;
			end
			OP_WRITE: begin
				if (idx_q != 3'd0) begin
					nx_rs   = 1'b1;
					nx_byte = desc_s1.char_byte;
				end
			end
			OP_BLINK: begin
				nx_byte = desc_s1.cmd_byte;
			end
			default: begin
				nx_byte = desc_s1.cmd_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emitting;
			end
			if (emitting) begin
				idx_q <= final_xfer ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emitting) begin
			reg_select_q   <= nx_rs;
			bus_byte_q     <= nx_byte;
			pause_before_q <= nx_before;
			pause_after_q  <= nx_after;
			is_last_q      <= final_xfer;
		end
	end

	assign out_valid       = out_valid_q;
	assign reg_select      = reg_select_q;
	assign bus_byte        = bus_byte_q;
	assign pause_before_ms = pause_before_q;
	assign pause_after_ms  = pause_after_q;
	assign is_last         = is_last_q;

endmodule

// ===== design/char_lcd_command_sequencer_core.sv =====
// Turns init, clear, write-character and set-blink requests into 8-bit bus
// transfers for a two-row character LCD (RS bit, data byte, pause before and
// after, and a last flag on the final transfer of each request). A request is
// decoded into a registered holding stage, and transfers then leave the
// output register at one per cycle while the output is not stalled: init
// sends 5 transfers, a character write 2, clear and set blink 1, and a
// character past the last column sends nothing. The next request is taken in
// the cycle its predecessor's final transfer enters the output register, so
// an output stall holds the input side only once the holding stage is full.
module char_lcd_command_sequencer_core
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic       row,
	input  logic [5:0] column,
	input  logic [7:0] character,
	input  logic       string_last,
	input  logic       blink_on,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reg_select,
	output logic [7:0] bus_byte,
	output logic [7:0] pause_before_ms,
	output logic [7:0] pause_after_ms,
	output logic       is_last
);

	cfg_t  cfg;
	logic  valid_s1;
	desc_t desc_s1;
	logic  release_s1;

	lcdseq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcdseq_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.row         (row),
		.column      (column),
		.character   (character),
		.string_last (string_last),
		.blink_on    (blink_on),
		.release_s1  (release_s1),
		.valid_s1    (valid_s1),
		.desc_s1     (desc_s1)
	);

	lcdseq_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.valid_s1        (valid_s1),
		.desc_s1         (desc_s1),
		.release_s1      (release_s1),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.reg_select      (reg_select),
		.bus_byte        (bus_byte),
		.pause_before_ms (pause_before_ms),
		.pause_after_ms  (pause_after_ms),
		.is_last         (is_last)
	);

endmodule

// ===== tb/lcd_transfer_checker.sv =====
module lcd_transfer_checker
	import lcdseq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] operation,
	input  logic       row,
	input  logic [5:0] column,
	input  logic [7:0] character,
	input  logic       string_last,
	input  logic       blink_on,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       reg_select,
	input  logic [7:0] bus_byte,
	input  logic [7:0] pause_before_ms,
	input  logic [7:0] pause_after_ms,
	input  logic       is_last,
	output int         fail_count,
	output int         expected_left
);

	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic [7:0] before_ms;
		logic [7:0] after_ms;
		logic       last;
	} transfer_t;

	transfer_t transfer_q[$];
	transfer_t want;
	transfer_t got;

	// Shadow copies of the programmed registers.
	logic [7:0] enable_us;
	logic [7:0] power_on_ms;
	logic [7:0] settle_ms;
	logic [7:0] clear_ms;
	logic [5:0] columns;

	// String tracking, mirrors the block's own state.
	logic       string_row_q;
	logic [6:0] column_q;
	logic       in_string;

	function automatic transfer_t make_transfer(input logic rs, input logic [7:0] data,
			input logic [7:0] before_ms, input logic [7:0] after_ms, input logic last);
		transfer_t t;
		t.rs = rs;
		t.data = data;
		t.before_ms = before_ms;
		t.after_ms = after_ms;
		t.last = last;
		return t;
	endfunction

	task automatic predict_request();
		logic [6:0] addr;
		case (op_t'(operation))
			OP_INIT: begin
				in_string = 1'b0;
				for (int i = 0; i < FUNCTION_SET_REPEATS; i++) begin
					transfer_q.push_back(make_transfer(1'b0, CMD_FUNCTION_SET,
						(i == 0) ? power_on_ms : 8'd0, settle_ms, 1'b0));
				end
				transfer_q.push_back(make_transfer(1'b0, CMD_DISPLAY_ON, 8'd0, settle_ms, 1'b0));
				transfer_q.push_back(make_transfer(1'b0, CMD_CLEAR, 8'd0, clear_ms, 1'b1));
			end
			OP_CLEAR: begin
				in_string = 1'b0;
				transfer_q.push_back(make_transfer(1'b0, CMD_CLEAR, 8'd0, clear_ms, 1'b1));
			end
			OP_BLINK: begin
				in_string = 1'b0;
				transfer_q.push_back(make_transfer(1'b0,
					blink_on ? (CMD_DISPLAY_ON | CURSOR_BLINK_BITS) : CMD_DISPLAY_ON,
					8'd0, 8'd0, 1'b1));
			end
			default: begin
				// The first character of a string takes its position from the request.
				if (!in_string) begin
					string_row_q = row;
					column_q = {1'b0, column};
				end
				if (column_q < {1'b0, columns}) begin
					addr = (string_row_q ? ROW1_BASE : 7'h00) + column_q;
					transfer_q.push_back(make_transfer(1'b0, CMD_SET_DDRAM | {1'b0, addr},
						8'd0, 8'd0, 1'b0));
					transfer_q.push_back(make_transfer(1'b1, character, 8'd0, 8'd0, 1'b1));
					column_q = column_q + 7'd1;
				end
				in_string = !string_last;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_us = 8'd40;
			power_on_ms = 8'd50;
			settle_ms = 8'd5;
			clear_ms = 8'd2;
			columns = 6'd16;
			string_row_q = 1'b0;
			column_q = 7'd0;
			in_string = 1'b0;
			transfer_q.delete();
			fail_count = 0;
			expected_left = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENABLE_PULSE_US:   enable_us = cfg_data;
					CFG_POWER_ON_DELAY_MS: power_on_ms = cfg_data;
					CFG_SETTLE_DELAY_MS:   settle_ms = cfg_data;
					CFG_CLEAR_DELAY_MS:    clear_ms = cfg_data;
					CFG_PANEL_COLUMNS:     columns = cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_request();
			if (out_valid && !out_stall) begin
				got = make_transfer(reg_select, bus_byte, pause_before_ms, pause_after_ms, is_last);
				if (transfer_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transfer: rs=%0d byte=%h before=%0d after=%0d last=%0d",
						$time, got.rs, got.data, got.before_ms, got.after_ms, got.last);
				end else begin
					want = transfer_q.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: transfer expected rs=%0d byte=%h before=%0d after=%0d last=%0d",
							$time, want.rs, want.data, want.before_ms, want.after_ms, want.last);
						$display("%0t: transfer actual   rs=%0d byte=%h before=%0d after=%0d last=%0d",
							$time, got.rs, got.data, got.before_ms, got.after_ms, got.last);
					end
				end
			end
			expected_left = transfer_q.size();
		end
	end

endmodule

// ===== tb/char_lcd_command_sequencer_core_tb.sv =====
module char_lcd_command_sequencer_core_tb;
	import lcdseq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_CYCLES = 20;
	localparam int PHASE_ITEMS = 42;
	// An index outside the register map; writes to it must change nothing.
	localparam logic [2:0] CFG_UNMAPPED = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] operation;
	logic       row;
	logic [5:0] column;
	logic [7:0] character;
	logic       string_last;
	logic       blink_on;
	logic       out_valid;
	logic       out_stall;
	logic       reg_select;
	logic [7:0] bus_byte;
	logic [7:0] pause_before_ms;
	logic [7:0] pause_after_ms;
	logic       is_last;

	int fail_count;
	int expected_left;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_stall_pct;
	int requests_sent = 0;
	int cols;
	int phase_start;

	char_lcd_command_sequencer_core dut (.*);
	lcd_transfer_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_command_sequencer_core: mismatch");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	task automatic send_request(input op_t op, input logic r, input logic [5:0] col,
			input logic [7:0] ch, input logic last, input logic blink);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		row <= r;
		column <= col;
		character <= ch;
		string_last <= last;
		blink_on <= blink;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Hold off new requests until every predicted transfer is out, then let a
	// dropped character finish inside the block.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PANEL_COLUMNS)
			cols = int'(val[5:0]);
	endtask

	task automatic program_random(input int columns_lo, input int columns_hi);
		write_reg(CFG_ENABLE_PULSE_US, 8'($urandom_range(1, 255)));
		write_reg(CFG_POWER_ON_DELAY_MS, 8'($urandom_range(0, 255)));
		write_reg(CFG_SETTLE_DELAY_MS, 8'($urandom_range(0, 255)));
		write_reg(CFG_CLEAR_DELAY_MS, 8'($urandom_range(0, 255)));
		write_reg(CFG_PANEL_COLUMNS, 8'($urandom_range(columns_lo, columns_hi)));
	endtask

	// A run of characters; later characters carry random row and column that
	// the block must ignore. Now and then the string is left open.
	task automatic send_string();
		int len;
		logic [5:0] c;
		logic left_open;
		len = $urandom_range(1, 6);
		left_open = ($urandom_range(0, 9) == 0);
		if (cols > 0 && $urandom_range(0, 3) != 0)
			c = 6'($urandom_range(0, cols - 1));
		else
			c = 6'($urandom_range(0, 63));
		for (int k = 0; k < len; k++) begin
			send_request(OP_WRITE, 1'($urandom_range(0, 1)),
				(k == 0) ? c : 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), (k == len - 1) && !left_open,
				1'($urandom_range(0, 1)));
		end
	endtask

	task automatic send_random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			send_request(OP_INIT, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else if (pick < 14)
			send_request(OP_CLEAR, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else if (pick < 24)
			send_request(OP_BLINK, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		else
			send_string();
	endtask

	task automatic random_phase();
		phase_start = requests_sent;
		while (requests_sent - phase_start < PHASE_ITEMS) begin
			if ($urandom_range(0, 29) == 0)
				drain();
			send_random_item();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = '0;
		row = 1'b0;
		column = '0;
		character = '0;
		string_last = 1'b0;
		blink_on = 1'b0;
		out_stall = 1'b0;
		send_idle_pct = 16;
		recv_stall_pct = 48;
		cols = 16;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values.
		send_request(OP_INIT, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0);
		send_request(OP_CLEAR, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b1);
		send_request(OP_BLINK, 1'b0, 6'd0, 8'h00, 1'b0, 1'b1);
		send_request(OP_BLINK, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b1, 6'd63, 8'hFF, 1'b0, 1'b1);
		send_request(OP_WRITE, 1'b1, 6'd20, 8'h41, 1'b1, 1'b0);
		// Last visible column, then one past it.
		send_request(OP_WRITE, 1'b1, 6'd15, 8'h5A, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd0, 8'hA5, 1'b1, 1'b0);
		send_request(OP_WRITE, 1'b1, 6'd63, 8'h7E, 1'b1, 1'b0);
		// Other requests close an open string.
		send_request(OP_WRITE, 1'b0, 6'd3, 8'h31, 1'b0, 1'b0);
		send_request(OP_BLINK, 1'b0, 6'd0, 8'h00, 1'b0, 1'b1);
		send_request(OP_WRITE, 1'b1, 6'd5, 8'h32, 1'b1, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd7, 8'h33, 1'b0, 1'b0);
		send_request(OP_INIT, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b1, 6'd0, 8'h34, 1'b0, 1'b0);
		send_request(OP_CLEAR, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd1, 8'h35, 1'b1, 1'b0);
		drain();

		// Upper extremes.
		write_reg(CFG_ENABLE_PULSE_US, 8'd255);
		write_reg(CFG_POWER_ON_DELAY_MS, 8'd255);
		write_reg(CFG_SETTLE_DELAY_MS, 8'd255);
		write_reg(CFG_CLEAR_DELAY_MS, 8'd255);
		write_reg(CFG_PANEL_COLUMNS, 8'd40);
		send_request(OP_INIT, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b1);
		send_request(OP_WRITE, 1'b1, 6'd39, 8'h80, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd0, 8'h7F, 1'b1, 1'b0);
		drain();

		// Lower extremes; with no columns every character is dropped.
		write_reg(CFG_ENABLE_PULSE_US, 8'd1);
		write_reg(CFG_POWER_ON_DELAY_MS, 8'd0);
		write_reg(CFG_SETTLE_DELAY_MS, 8'd0);
		write_reg(CFG_CLEAR_DELAY_MS, 8'd0);
		write_reg(CFG_PANEL_COLUMNS, 8'd0);
		write_reg(CFG_UNMAPPED, 8'hFF);
		send_request(OP_INIT, 1'b0, 6'd0, 8'h00, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd0, 8'h44, 1'b1, 1'b0);
		send_request(OP_CLEAR, 1'b0, 6'd0, 8'h00, 1'b1, 1'b0);
		drain();

		// Widest column register, highest DDRAM address.
		write_reg(CFG_PANEL_COLUMNS, 8'd63);
		send_request(OP_WRITE, 1'b1, 6'd62, 8'hC3, 1'b0, 1'b0);
		send_request(OP_WRITE, 1'b0, 6'd0, 8'h3C, 1'b1, 1'b0);
		drain();

		program_random(16, 16);
		random_phase();

		send_idle_pct = 48;
		recv_stall_pct = 16;
		program_random(1, 40);
		random_phase();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_random(1, 8);
		random_phase();

		if (fail_count == 0 && expected_left == 0)
			$display("char_lcd_command_sequencer_core: match");
		else
			$display("char_lcd_command_sequencer_core: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lcdseq_pkg.sv
design/lcdseq_cfg.sv
design/lcdseq_decode.sv
design/lcdseq_emit.sv
design/char_lcd_command_sequencer_core.sv
tb/lcd_transfer_checker.sv
tb/char_lcd_command_sequencer_core_tb.sv
